### src/ipid_pkg.sv
// shared types and constants of the incremental pid speed loop
package ipid_pkg;

  localparam int GAIN_WIDTH    = 24;
  localparam int ACC_WIDTH     = 30;
  localparam int FRAC_BITS     = 16;
  localparam int PRODUCT_SHIFT = 12;
  localparam int DRIVE_WIDTH   = 14;
  localparam int SAT_COUNTS    = 6500;
  localparam int DEAD_COUNTS   = 100;
  localparam int SAT_LIMIT     = SAT_COUNTS * (2 ** FRAC_BITS);
  localparam int DEAD_LIMIT    = DEAD_COUNTS * (2 ** FRAC_BITS);
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0] kp;
    logic [GAIN_WIDTH-1:0] ki;
    logic [GAIN_WIDTH-1:0] kd;
  } gains_t;

endpackage

### src/ipid_if.sv
// request channel interfaces for speed input and drive output

interface ipid_in_if #(
  parameter int SPEED_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] measured_speed;
  logic signed [SPEED_WIDTH-1:0] target_speed;

  modport source (output valid, output measured_speed, output target_speed, input ready);
  modport sink   (input valid, input measured_speed, input target_speed, output ready);
endinterface

interface ipid_out_if;
  logic        valid;
  logic        ready;
  logic signed [13:0] drive_value;

  modport source (output valid, output drive_value, input ready);
  modport sink   (input valid, input drive_value, output ready);
endinterface

### src/incremental_pid_speed_loop.sv
// a request passes the input register, then the result register, before its drive result is valid
// throughput: one request per cycle while drive results are taken; a stalled result still lets one request enter
// the critical path is three parallel gain multipliers, a four-term add and saturation
// reset (async, active low) clears gains, error history, accumulator and valid flags
// no clearing pass: the block takes requests in the first cycle after reset
module incremental_pid_speed_loop
  import ipid_pkg::*;
#(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ipid_in_if.sink                   speed_i,
  ipid_out_if.source                drive_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  // gain registers
  gains_t gains;

  ipid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  // input stage
  logic                          in_valid_q;
  logic signed [SPEED_WIDTH-1:0] meas_q, targ_q;

  // controller state
  logic signed [SPEED_WIDTH:0]   err_prev_q, err_prev2_q;
  logic signed [ACC_WIDTH-1:0]   acc_q;

  // result stage
  logic                          out_valid_q;
  logic signed [DRIVE_WIDTH-1:0] drive_q;

  logic                          in_accept;
  logic                          advance;
  logic signed [SPEED_WIDTH:0]   err_d;
  logic signed [ACC_WIDTH-1:0]   acc_d;
  logic signed [DRIVE_WIDTH-1:0] drive_d;

  // the input stage moves on whenever the result register is empty or being drained
  assign advance       = in_valid_q && (!out_valid_q || drive_o.ready);
  assign speed_i.ready = !in_valid_q || advance;
  assign in_accept     = speed_i.valid && speed_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      meas_q <= speed_i.measured_speed;
      targ_q <= speed_i.target_speed;
    end
  end

  ipid_update #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_update (
    .measured_i  (meas_q),
    .target_i    (targ_q),
    .err_prev_i  (err_prev_q),
    .err_prev2_i (err_prev2_q),
    .acc_i       (acc_q),
    .gains_i     (gains),
    .err_o       (err_d),
    .acc_o       (acc_d),
    .drive_o     (drive_d)
  );

  // state commits together with the result so back-to-back requests see fresh history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_prev_q  <= '0;
      err_prev2_q <= '0;
      acc_q       <= '0;
    end else if (advance) begin
      err_prev2_q <= err_prev_q;
      err_prev_q  <= err_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (drive_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o.valid       = out_valid_q;
  assign drive_o.drive_value = drive_q;

endmodule

### src/ipid_regs.sv
// apb gain registers
module ipid_regs
  import ipid_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output gains_t                    gains_o
);

  gains_t   gains_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign idx     = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign gains_o = gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P: gains_q.kp <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_I: gains_q.ki <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_D: gains_q.kd <= pwdata[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P: prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, gains_q.kp};
      REG_GAIN_I: prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, gains_q.ki};
      REG_GAIN_D: prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, gains_q.kd};
      default:    prdata = '0;
    endcase
  end

endmodule

### src/ipid_update.sv
// one pid increment: error, differences, gain products, saturation, deadband
module ipid_update
  import ipid_pkg::*;
#(
  parameter int SPEED_WIDTH = 16
) (
  input  logic signed [SPEED_WIDTH-1:0] measured_i,
  input  logic signed [SPEED_WIDTH-1:0] target_i,
  input  logic signed [SPEED_WIDTH:0]   err_prev_i,
  input  logic signed [SPEED_WIDTH:0]   err_prev2_i,
  input  logic signed [ACC_WIDTH-1:0]   acc_i,
  input  gains_t                        gains_i,
  output logic signed [SPEED_WIDTH:0]   err_o,
  output logic signed [ACC_WIDTH-1:0]   acc_o,
  output logic signed [DRIVE_WIDTH-1:0] drive_o
);

  localparam int EW = SPEED_WIDTH + 1;
  localparam int DW = SPEED_WIDTH + 3;
  localparam int GW = GAIN_WIDTH + 1;
  localparam int PW = DW + GW;
  localparam int SW = PW - PRODUCT_SHIFT;
  localparam int AW = ((SW > ACC_WIDTH) ? SW : ACC_WIDTH) + 2;

  localparam logic signed [AW-1:0] SatPos  = AW'(SAT_LIMIT);
  localparam logic signed [AW-1:0] SatNeg  = -AW'(SAT_LIMIT);
  localparam logic signed [AW-1:0] DeadPos = AW'(DEAD_LIMIT);
  localparam logic signed [AW-1:0] DeadNeg = -AW'(DEAD_LIMIT);
  localparam logic [ACC_WIDTH-1:0] FracMask = ACC_WIDTH'((2 ** FRAC_BITS) - 1);

  logic signed [EW-1:0]        err;
  logic signed [DW-1:0]        err_x, e1_x, e2_x, d1, d2, di;
  logic signed [GW-1:0]        kp, ki, kd;
  logic signed [PW-1:0]        prod_p, prod_i, prod_d;
  logic signed [SW-1:0]        tp, ti, td;
  logic signed [AW-1:0]        sum, sat;
  logic signed [ACC_WIDTH-1:0] acc_new, acc_bias;

  assign err = {target_i[SPEED_WIDTH-1], target_i} - {measured_i[SPEED_WIDTH-1], measured_i};

  assign err_x = {{(DW-EW){err[EW-1]}}, err};
  assign e1_x  = {{(DW-EW){err_prev_i[EW-1]}}, err_prev_i};
  assign e2_x  = {{(DW-EW){err_prev2_i[EW-1]}}, err_prev2_i};
  assign d1    = err_x - e1_x;
  assign d2    = err_x - (e1_x <<< 1) + e2_x;
  assign di    = err_x;

  assign kp = {1'b0, gains_i.kp};
  assign ki = {1'b0, gains_i.ki};
  assign kd = {1'b0, gains_i.kd};

  assign prod_p = d1 * kp;
  assign prod_i = di * ki;
  assign prod_d = d2 * kd;

  // dropping the low bits of a two's complement product rounds toward minus infinity
  assign tp = prod_p[PW-1:PRODUCT_SHIFT];
  assign ti = prod_i[PW-1:PRODUCT_SHIFT];
  assign td = prod_d[PW-1:PRODUCT_SHIFT];

  assign sum = {{(AW-ACC_WIDTH){acc_i[ACC_WIDTH-1]}}, acc_i}
             + {{(AW-SW){tp[SW-1]}}, tp}
             + {{(AW-SW){ti[SW-1]}}, ti}
             + {{(AW-SW){td[SW-1]}}, td};

  always_comb begin
    if (sum > SatPos) begin
      sat = SatPos;
    end else if (sum < SatNeg) begin
      sat = SatNeg;
    end else if ((sum < DeadPos) && (sum > DeadNeg)) begin
      sat = '0;
    end else begin
      sat = sum;
    end
  end

  assign acc_new = sat[ACC_WIDTH-1:0];

  // truncate toward zero: bias negative values before dropping the fraction
  assign acc_bias = acc_new + (acc_new[ACC_WIDTH-1] ? FracMask : '0);

  assign err_o   = err;
  assign acc_o   = acc_new;
  assign drive_o = acc_bias[ACC_WIDTH-1:FRAC_BITS];

endmodule

### src/ipid_checker.sv
// port-level checks for the pid speed loop, bound to the top level
module ipid_checker
  import ipid_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [DRIVE_WIDTH-1:0] drive_value_i
);

  localparam logic signed [DRIVE_WIDTH-1:0] SatMax  = DRIVE_WIDTH'(SAT_COUNTS);
  localparam logic signed [DRIVE_WIDTH-1:0] DeadMin = DRIVE_WIDTH'(DEAD_COUNTS);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("drive result dropped while stalled");

  // with no result pending the block always takes an offered request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !out_valid_i) |-> in_ready_i)
    else $error("request refused with empty output");

  // drive stays within saturation limits
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((drive_value_i <= SatMax) && (drive_value_i >= -SatMax)))
    else $error("drive outside saturation range");

  // nothing small but zero leaves the deadband
  a_deadband: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((drive_value_i == '0) || (drive_value_i >= DeadMin)
                     || (drive_value_i <= -DeadMin)))
    else $error("drive inside deadband is not zero");

endmodule

bind incremental_pid_speed_loop ipid_checker u_ipid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (speed_i.valid),
  .in_ready_i    (speed_i.ready),
  .out_valid_i   (drive_o.valid),
  .out_ready_i   (drive_o.ready),
  .drive_value_i (drive_o.drive_value)
);
